// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge, muted while reset is low.
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Two signals that must never be high together.
`define ASSERT_NEVER_BOTH(lbl, clk, rst_n, a, b, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !((a) && (b))) else $error(msg);

`endif

// ===== hw/rtl/bse_pkg.sv =====
// Package for the bubble sort engine: sizes, payload structs, store port struct.
// No dependencies.
package bse_pkg;

	localparam int ENTRIES = 16;
	localparam int IDX_W   = $clog2(ENTRIES);
	localparam int CNT_W   = $clog2(ENTRIES + 1);

	typedef struct packed {
		logic signed [31:0] value;
		logic               last_in;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] sorted_value;
		logic               last_out;
		logic               overflow;
	} out_item_t;

	typedef struct packed {
		logic               we;
		logic [IDX_W-1:0]   waddr;
		logic signed [31:0] wdata;
		logic               re;
		logic [IDX_W-1:0]   raddr;
	} store_req_t;

endpackage

// ===== hw/rtl/bse_store.sv =====
// Element store: one write port, one read port with registered read data.
// Depends on bse_pkg.
module bse_store import bse_pkg::*; (
	input  logic               clk,
	input  store_req_t         req,
	output logic signed [31:0] rd_data_q
);

	logic [31:0] mem [ENTRIES];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
		if (req.re) begin
			rd_data_q <= $signed(mem[req.raddr]);
		end
	end

endmodule

// ===== hw/rtl/bse_seq.sv =====
// Sequencer: collects the set, runs bubble passes through one comparator,
// then reads the sorted store out. Depends on bse_pkg.
module bse_seq import bse_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  in_item_t           in_item,
	output logic               in_ready,
	output store_req_t         req,
	input  logic signed [31:0] rd_data,
	output logic               emit_load,
	output out_item_t          emit_item,
	input  logic               out_taken
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_PASS_START,
		S_PASS_FIRST,
		S_SCAN,
		S_PASS_END,
		S_EMIT_RD,
		S_EMIT_LD,
		S_EMIT_WAIT
	} state_t;

	state_t             state_q;
	logic [IDX_W-1:0]   idx_q;
	logic [IDX_W-1:0]   end_q;
	logic [CNT_W-1:0]   count_q;
	logic               drop_q;
	logic signed [31:0] carry_q;

	logic             in_acc;
	logic             has_room;
	logic [CNT_W-1:0] n_final;
	logic             swap;
	logic             scan_done;
	logic             is_last;

	assign in_ready  = (state_q == S_IDLE);
	assign in_acc    = in_valid && in_ready;
	assign has_room  = (count_q < CNT_W'(ENTRIES));
	assign n_final   = has_room ? count_q + CNT_W'(1) : count_q;
	// strictly greater only, so equal values keep arrival order
	assign swap      = (carry_q > rd_data);
	assign scan_done = ((CNT_W'(idx_q) + CNT_W'(1)) == CNT_W'(end_q));
	assign is_last   = ((CNT_W'(idx_q) + CNT_W'(1)) == count_q);

	always_comb begin
		req       = '0;
		emit_load = 1'b0;
		emit_item.sorted_value = rd_data;
		emit_item.last_out     = is_last;
		emit_item.overflow     = drop_q;
		case (state_q)
			S_IDLE: begin
				req.we    = in_acc && has_room;
				req.waddr = count_q[IDX_W-1:0];
				req.wdata = in_item.value;
			end
			S_PASS_START: begin
				req.re    = 1'b1;
				req.raddr = '0;
			end
			S_PASS_FIRST: begin
				req.re    = 1'b1;
				req.raddr = IDX_W'(1);
			end
			S_SCAN: begin
				// the larger value travels on in carry_q, the smaller is written back
				req.we    = 1'b1;
				req.waddr = idx_q;
				req.wdata = swap ? rd_data : carry_q;
				req.re    = !scan_done;
				req.raddr = idx_q + IDX_W'(2);
			end
			S_PASS_END: begin
				req.we    = 1'b1;
				req.waddr = end_q;
				req.wdata = carry_q;
			end
			S_EMIT_RD: begin
				req.re    = 1'b1;
				req.raddr = idx_q;
			end
			S_EMIT_LD: begin
				emit_load = 1'b1;
			end
			S_EMIT_WAIT: begin
				req.re    = out_taken && !is_last;
				req.raddr = idx_q + IDX_W'(1);
			end
			default: begin
				req = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			idx_q   <= '0;
			end_q   <= '0;
			count_q <= '0;
			drop_q  <= 1'b0;
			carry_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						if (has_room) begin
							count_q <= count_q + CNT_W'(1);
						end else begin
							drop_q <= 1'b1;
						end
						if (in_item.last_in) begin
							idx_q <= '0;
							end_q <= IDX_W'(n_final - CNT_W'(1));
							if (n_final < CNT_W'(2)) begin
								state_q <= S_EMIT_RD;
							end else begin
								state_q <= S_PASS_START;
							end
						end
					end
				end
				S_PASS_START: begin
					state_q <= S_PASS_FIRST;
				end
				S_PASS_FIRST: begin
					carry_q <= rd_data;
					idx_q   <= '0;
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					if (!swap) begin
						carry_q <= rd_data;
					end
					if (scan_done) begin
						state_q <= S_PASS_END;
					end else begin
						idx_q <= idx_q + IDX_W'(1);
					end
				end
				S_PASS_END: begin
					idx_q <= '0;
					if (end_q == IDX_W'(1)) begin
						state_q <= S_EMIT_RD;
					end else begin
						end_q   <= end_q - IDX_W'(1);
						state_q <= S_PASS_START;
					end
				end
				S_EMIT_RD: begin
					state_q <= S_EMIT_LD;
				end
				S_EMIT_LD: begin
					state_q <= S_EMIT_WAIT;
				end
				S_EMIT_WAIT: begin
					if (out_taken) begin
						if (is_last) begin
							count_q <= '0;
							drop_q  <= 1'b0;
							state_q <= S_IDLE;
						end else begin
							idx_q   <= idx_q + IDX_W'(1);
							state_q <= S_EMIT_LD;
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== hw/rtl/bubble_sort_engine.sv =====
// While collecting, in_ready stays high, so input transactions are accepted back to back. A
// collected set then sorts in bubble passes, one compare each cycle through the shared comparator
// and the single-port-read store, then reads the first result from the store and loads each
// further result into the output register only after the previous one is taken.
// Not ready from the final input until the last result is taken.
// Reset clears state, element count, overflow flag and output valid; the store is not cleared.
module bubble_sort_engine import bse_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	input  in_item_t  in_item,
	output logic      out_valid,
	input  logic      out_ready,
	output out_item_t out_item
);

	store_req_t         req;
	logic signed [31:0] rd_data_q;
	logic               emit_load;
	out_item_t          emit_item;
	logic               out_taken;
	logic               out_valid_q;
	out_item_t          out_item_q;

	assign out_taken = out_valid_q && out_ready;
	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	bse_store u_store (
		.clk       (clk),
		.req       (req),
		.rd_data_q (rd_data_q)
	);

	bse_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_item   (in_item),
		.in_ready  (in_ready),
		.req       (req),
		.rd_data   (rd_data_q),
		.emit_load (emit_load),
		.emit_item (emit_item),
		.out_taken (out_taken)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_load) begin
			out_valid_q <= 1'b1;
		end else if (out_taken) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_load) begin
			out_item_q <= emit_item;
		end
	end

endmodule

// ===== hw/rtl/bse_checker.sv =====
// Port-level checker for the bubble sort engine, bound to the top level.
// Depends on bse_pkg and assert_macros.svh.
`include "assert_macros.svh"

module bse_checker import bse_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_ready,
	input in_item_t  in_item,
	input logic      out_valid,
	input logic      out_ready,
	input out_item_t out_item
);

	`ASSERT_CLK(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid && $stable(out_item), "result changed while stalled")
	`ASSERT_NEVER_BOTH(a_no_overlap, clk, arst_n, in_ready, out_valid, "input taken while result pending")
	`ASSERT_CLK(a_last_busy, clk, arst_n, in_valid && in_ready && in_item.last_in |=> !in_ready, "not busy after final transaction")
	`ASSERT_CLK(a_done_ready, clk, arst_n, out_valid && out_ready && out_item.last_out |=> in_ready, "not ready after last result")

endmodule

bind bubble_sort_engine bse_checker u_chk (.*);
